FILE: hw/rtl/cmap_pkg.sv
// Shared types and constants for the segmented character-to-glyph lookup.
`default_nettype none
package cmap_pkg;

  // Width of the internal address sums (segment bases, glyph array address)
  localparam int SUM_W = 18;
  localparam int SEG_W = 11;

  localparam logic [SUM_W-1:0] END_BASE = SUM_W'(7);
  localparam logic [SUM_W-1:0] SEG_BASE = SUM_W'(8);
  localparam logic [15:0]      OFF_SKIP = 16'hFFFF;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic REG_SEGMENT_COUNT = 1'b0;
  localparam logic REG_GLYPH_COUNT   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [12:0] word_address;
    logic [15:0] word_value;
    logic [15:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] glyph_id;
  } out_item_t;

  // Operand selection for the shared adder
  typedef logic [3:0] agu_sel_t;
  localparam agu_sel_t AGU_ZERO       = 4'd0;
  localparam agu_sel_t AGU_END_MID    = 4'd1;
  localparam agu_sel_t AGU_START_IDX  = 4'd2;
  localparam agu_sel_t AGU_END_IDX    = 4'd3;
  localparam agu_sel_t AGU_DELTA_IDX  = 4'd4;
  localparam agu_sel_t AGU_OFF_IDX    = 4'd5;
  localparam agu_sel_t AGU_HOLD_HALF  = 4'd6;
  localparam agu_sel_t AGU_HOLD_CST   = 4'd7;
  localparam agu_sel_t AGU_CODE_DELTA = 4'd8;
  localparam agu_sel_t AGU_WORD_DELTA = 4'd9;

  typedef struct packed {
    logic [SEG_W-1:0] mid;
    logic [SEG_W-1:0] idx;
    logic [SUM_W-1:0] starts;
    logic [SUM_W-1:0] deltas;
    logic [SUM_W-1:0] offs;
    logic [SUM_W-1:0] hold;
    logic [14:0]      off_half;
    logic [15:0]      cst;
    logic [15:0]      code;
    logic [15:0]      delta;
    logic [15:0]      word;
  } agu_src_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cmap_segment_glyph_lookup_core.sv
// Top level: configuration registers, lookup sequencer, table memory and shared adder.
// A table write is taken while idle and leaves the block idle, ready for the next item.
// A lookup over n segments makes s <= ceil(log2(n+1)) search steps, then reads the segment's
// start, end, delta and offset words (and the glyph array word when the offset is nonzero),
// repeating these reads for each skipped segment; input stalls until the result register is loaded.
// Synchronous reset idles the sequencer, clears result valid and sets the registers to 1 and 0; not the table.
`default_nettype none
module cmap_segment_glyph_lookup_core #(
  parameter int TABLE_WORDS = 8192
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire cmap_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cmap_pkg::out_item_t      out_item,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import cmap_pkg::*;

  localparam int AW = $clog2(TABLE_WORDS);
  localparam logic [SUM_W-1:0] TBL_LIMIT = SUM_W'(TABLE_WORDS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_NEXT = 4'd3;
  localparam logic [3:0] S_ST   = 4'd4;
  localparam logic [3:0] S_EN   = 4'd5;
  localparam logic [3:0] S_DL   = 4'd6;
  localparam logic [3:0] S_OF   = 4'd7;
  localparam logic [3:0] S_GA   = 4'd8;
  localparam logic [3:0] S_GV   = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]       state;
  logic [SEG_W-1:0] segment_count;
  logic [15:0]      glyph_count;

  logic [SEG_W-1:0] n_reg;
  logic [SEG_W-1:0] lo;
  logic [SEG_W-1:0] hi;
  logic [SEG_W-1:0] mid;
  logic [SEG_W-1:0] idx;
  logic [SUM_W-1:0] starts;
  logic [SUM_W-1:0] deltas;
  logic [SUM_W-1:0] offs;
  logic [SUM_W-1:0] addr_hold;
  logic [15:0]      code;
  logic [15:0]      cst;
  logic [15:0]      delta;
  logic             res_found;
  logic [15:0]      res_glyph;

  logic [SEG_W-1:0] mid_calc;
  logic [SUM_W-1:0] seg_n;
  logic [SUM_W-1:0] tbl_need;
  logic [15:0]      mem_q;
  logic             ram_we;
  agu_sel_t         agu_sel;
  agu_src_t         agu_src;
  logic [SUM_W-1:0] agu_sum;
  logic             in_take;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign mid_calc = lo + ((hi - lo) >> 1);
  assign seg_n    = SUM_W'(segment_count);
  assign tbl_need = SEG_BASE + (seg_n << 2);
  assign ram_we   = in_take && (in_item.kind == KIND_WRITE)
                    && (SUM_W'(in_item.word_address) < TBL_LIMIT);

  always_comb begin
    agu_src.mid      = mid_calc;
    agu_src.idx      = idx;
    agu_src.starts   = starts;
    agu_src.deltas   = deltas;
    agu_src.offs     = offs;
    agu_src.hold     = addr_hold;
    agu_src.off_half = mem_q[15:1];
    agu_src.cst      = cst;
    agu_src.code     = code;
    agu_src.delta    = delta;
    agu_src.word     = mem_q;
    case (state)
      S_SRCH: agu_sel = AGU_END_MID;
      S_NEXT: agu_sel = AGU_START_IDX;
      S_ST:   agu_sel = AGU_END_IDX;
      S_EN:   agu_sel = AGU_DELTA_IDX;
      S_DL:   agu_sel = AGU_OFF_IDX;
      S_OF:   agu_sel = (mem_q == 16'd0) ? AGU_CODE_DELTA : AGU_HOLD_HALF;
      S_GA:   agu_sel = AGU_HOLD_CST;
      S_GV:   agu_sel = (mem_q != 16'd0) ? AGU_WORD_DELTA : AGU_ZERO;
      default: agu_sel = AGU_ZERO;
    endcase
  end

  cmap_agu u_agu (
    .sel (agu_sel),
    .src (agu_src),
    .sum (agu_sum)
  );

  cmap_table_ram #(
    .DEPTH (TABLE_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_item.word_address)),
    .wdata (in_item.word_value),
    .raddr (AW'(agu_sum)),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      segment_count <= SEG_W'(1);
      glyph_count   <= 16'd0;
    end else begin
      addr_hold <= agu_sum;
      if (cfg_write) begin
        case (cfg_index)
          REG_SEGMENT_COUNT: segment_count <= cfg_data[SEG_W-1:0];
          REG_GLYPH_COUNT:   glyph_count   <= cfg_data;
          default: ;
        endcase
      end
      // the output state reloads the register itself
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take && (in_item.kind == KIND_LOOKUP)) begin
            code   <= in_item.char_code;
            n_reg  <= segment_count;
            starts <= SEG_BASE + seg_n;
            deltas <= SEG_BASE + (seg_n << 1);
            offs   <= SEG_BASE + (seg_n << 1) + seg_n;
            lo     <= '0;
            hi     <= segment_count;
            if (segment_count == '0 || tbl_need > TBL_LIMIT) begin
              res_found <= 1'b0;
              res_glyph <= 16'd0;
              state     <= S_OUT;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_calc;
            state <= S_SCMP;
          end else begin
            idx   <= lo;
            state <= S_NEXT;
          end
        end
        S_SCMP: begin
          if (mem_q < code) begin
            lo <= mid + SEG_W'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_NEXT: begin
          if (idx >= n_reg) begin
            res_found <= 1'b0;
            res_glyph <= 16'd0;
            state     <= S_OUT;
          end else begin
            state <= S_ST;
          end
        end
        S_ST: begin
          if (mem_q > code) begin
            res_found <= 1'b0;
            res_glyph <= 16'd0;
            state     <= S_OUT;
          end else begin
            cst   <= code - mem_q;
            state <= S_EN;
          end
        end
        S_EN: begin
          if (mem_q < code) begin
            res_found <= 1'b0;
            res_glyph <= 16'd0;
            state     <= S_OUT;
          end else begin
            state <= S_DL;
          end
        end
        S_DL: begin
          delta <= mem_q;
          state <= S_OF;
        end
        S_OF: begin
          // skip marker: try the following segment
          if (mem_q == OFF_SKIP) begin
            idx   <= idx + SEG_W'(1);
            state <= S_NEXT;
          end else if (mem_q == 16'd0) begin
            state <= S_FIN;
          end else begin
            state <= S_GA;
          end
        end
        S_GA: begin
          if (agu_sum >= TBL_LIMIT) begin
            res_found <= 1'b0;
            res_glyph <= 16'd0;
            state     <= S_OUT;
          end else begin
            state <= S_GV;
          end
        end
        S_GV: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (addr_hold[15:0] > glyph_count) begin
            res_found <= 1'b0;
            res_glyph <= 16'd0;
          end else begin
            res_found <= 1'b1;
            res_glyph <= addr_hold[15:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the result register is free
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_item.found     <= res_found;
            out_item.glyph_id  <= res_glyph;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_gv_after_ga: assert property (@(posedge clk) disable iff (rst)
    state == S_GV |-> $past(state) == S_GA)
    else $error("glyph word consumed without an address check");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH || state == S_SCMP) |-> (lo <= hi && hi <= n_reg))
    else $error("binary search bounds out of order");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCMP |-> (mid >= lo && mid < hi))
    else $error("search midpoint outside the interval");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !(out_valid && out_stall)) |=> out_valid && state == S_IDLE)
    else $error("finished result not transferred to the output register");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.found) |-> out_item.glyph_id == 16'd0)
    else $error("not-found result carries a nonzero index");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/cmap_table_ram.sv
// Table word memory: one write port, one read port with registered read data.
`default_nettype none
module cmap_table_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cmap_agu.sv
// Shared adder: forms every table address and the delta-adjusted glyph index.
`default_nettype none
module cmap_agu (
  input  wire cmap_pkg::agu_sel_t         sel,
  input  wire cmap_pkg::agu_src_t         src,
  output logic [cmap_pkg::SUM_W-1:0]      sum
);
  import cmap_pkg::*;

  logic [SUM_W-1:0] op_a;
  logic [SUM_W-1:0] op_b;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (sel)
      AGU_END_MID: begin
        op_a = END_BASE;
        op_b = SUM_W'(src.mid);
      end
      AGU_START_IDX: begin
        op_a = src.starts;
        op_b = SUM_W'(src.idx);
      end
      AGU_END_IDX: begin
        op_a = END_BASE;
        op_b = SUM_W'(src.idx);
      end
      AGU_DELTA_IDX: begin
        op_a = src.deltas;
        op_b = SUM_W'(src.idx);
      end
      AGU_OFF_IDX: begin
        op_a = src.offs;
        op_b = SUM_W'(src.idx);
      end
      AGU_HOLD_HALF: begin
        op_a = src.hold;
        op_b = SUM_W'(src.off_half);
      end
      AGU_HOLD_CST: begin
        op_a = src.hold;
        op_b = SUM_W'(src.cst);
      end
      AGU_CODE_DELTA: begin
        op_a = SUM_W'(src.code);
        op_b = SUM_W'(src.delta);
      end
      AGU_WORD_DELTA: begin
        op_a = SUM_W'(src.word);
        op_b = SUM_W'(src.delta);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sum = op_a + op_b;

endmodule
`default_nettype wire
